// File: rtl/core/spdz_pkg.sv
// ----------------------------------------------------------------------------
// spdz_pkg: shared constants and types for the stick polar dead-zone core
// Holds the CORDIC angle table, fixed widths and the data record that moves
// from cell to cell down the pipeline.
// ----------------------------------------------------------------------------
package spdz_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TABLE_LEN         = 24;
   localparam int SQRT_STEPS        = 24;   // result bits of sqrt(r2 << 16)
   localparam int DIV_STEPS         = 16;   // quotient bits of the magnitude divide
   localparam int DEADZONE_RESET    = 7849;
   localparam int AXIS_MAX          = 32767;

   localparam logic [33:0] QUARTER_TURN = 34'd1073741824;
   localparam logic [23:0] TWO_PI_Q21   = 24'd13176795;

   // Rounded atan(2^-i) in units of 2^-32 turn.
   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] v;
      begin
         case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
         endcase
         return v;
      end
   endfunction

   // One beat in flight through the cell chain.
   typedef struct packed {
      logic        valid;
      // square root (bitwise restoring)
      logic [47:0] sq_rem;     // remaining radicand
      logic [47:0] sq_res;
      logic [47:0] sq_bit;
      // divider
      logic [39:0] dv_rem;
      logic [15:0] dv_quo;
      logic [23:0] dv_den;
      // CORDIC
      logic [33:0] cx;         // non-negative
      logic signed [34:0] cy;
      logic signed [35:0] z;
      logic [33:0] base;
      logic        axis;       // angle is exact, CORDIC result unused
      // flags
      logic        dz_hit;
      logic        mag_on;     // r2 > dz2 and divisor non-zero
      logic [14:0] dz;
   } spdz_beat_type;

endpackage

// File: rtl/core/spdz_cell.sv
// ----------------------------------------------------------------------------
// spdz_cell: one step of the pipeline
// Performs one square-root bit or, in its divider window, one quotient bit (the
// first divider cell also clips and seeds), plus a CORDIC rotation below
// CORDIC_STAGES; registers the beat onward.
module spdz_cell #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = spdz_pkg::CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  spdz_pkg::spdz_beat_type beat_in,
   output spdz_pkg::spdz_beat_type beat_out
);

   localparam int DIV_START = spdz_pkg::SQRT_STEPS;
   localparam int DIV_BIT   = (IDX >= DIV_START && IDX < DIV_START + spdz_pkg::DIV_STEPS)
                              ? DIV_START + spdz_pkg::DIV_STEPS - 1 - IDX : 0;

   spdz_pkg::spdz_beat_type beat_ff, beat_in_c;
   logic [47:0] trial;
   logic [33:0] xs, ys;
   logic [33:0] ycomp;
   logic [39:0] rem_sh;
   logic [39:0] den_sh;
   logic [23:0] rq;
   logic [23:0] rq_off;

   always_comb begin
      beat_in_c = beat_in;
      trial     = '0;
      xs        = '0;
      ys        = '0;
      ycomp     = '0;
      rem_sh    = '0;
      den_sh    = '0;
      rq        = '0;
      rq_off    = '0;
      if (IDX < spdz_pkg::SQRT_STEPS) begin
         trial = beat_in.sq_res + beat_in.sq_bit;
         if (beat_in.sq_rem >= trial) begin
            beat_in_c.sq_rem = beat_in.sq_rem - trial;
            beat_in_c.sq_res = (beat_in.sq_res >> 1) + beat_in.sq_bit;
         end else begin
            beat_in_c.sq_res = beat_in.sq_res >> 1;
         end
         beat_in_c.sq_bit = beat_in.sq_bit >> 2;
      end
      if (IDX == DIV_START) begin
         // Clip the radius, remove the dead zone and seed the divider with
         // ((rq - (dz << 8)) << 15) + den/2.
         rq = beat_in.sq_res[23:0];
         if (rq > 24'(spdz_pkg::AXIS_MAX * 256)) rq = 24'(spdz_pkg::AXIS_MAX * 256);
         rq_off = rq - {1'b0, beat_in.dz, 8'd0};
         beat_in_c.dv_rem = {1'b0, rq_off, 15'd0} + {17'd0, beat_in.dv_den[23:1]};
         beat_in_c.dv_quo = '0;
      end
      if (IDX >= DIV_START && IDX < DIV_START + spdz_pkg::DIV_STEPS) begin
         // Restoring divide, most significant quotient bit first.
         rem_sh = beat_in_c.dv_rem;
         den_sh = 40'(beat_in.dv_den) << DIV_BIT;
         if (rem_sh >= den_sh) begin
            beat_in_c.dv_rem = rem_sh - den_sh;
            beat_in_c.dv_quo = beat_in_c.dv_quo | (16'd1 << DIV_BIT);
         end
      end
      if (IDX < CORDIC_STAGES) begin
         ycomp = beat_in.cy[34] ? 34'(-beat_in.cy) : 34'(beat_in.cy);
         xs = beat_in.cx >> IDX;
         ys = ycomp >> IDX;
         beat_in_c.cx = beat_in.cx + ys;
         if (!beat_in.cy[34]) begin
            beat_in_c.cy = beat_in.cy - $signed({1'b0, xs});
            beat_in_c.z  = beat_in.z + 36'(spdz_pkg::atan_turn(5'(IDX)));
         end else begin
            beat_in_c.cy = beat_in.cy + $signed({1'b0, xs});
            beat_in_c.z  = beat_in.z - 36'(spdz_pkg::atan_turn(5'(IDX)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_c;
      end
   end

   assign beat_out = beat_ff;

endmodule

// File: rtl/core/stick_polar_deadzone_core.sv
// ----------------------------------------------------------------------------
// stick_polar_deadzone_core: polar reading of one thumbstick with dead zone
// A chain of identical cells computes radius, normalized magnitude and
// CORDIC direction for the selected stick.
// ----------------------------------------------------------------------------
// One request beat enters per cycle unless a stalled response holds the
// chain. Each beat passes one front cell, then SQRT_STEPS + DIV_STEPS chain
// cells (40 with the defaults), then the angle scale cell and the output
// register. The length is set by the bit-serial square root and the
// restoring divider that share the chain; the CORDIC rotations ride in the
// first CORDIC_STAGES cells. The whole chain advances whenever the output
// register is empty or being drained, so a stalled response holds every
// beat in place. The dead zone register is written by csr_wr_en and applies
// to beats that enter afterwards.
module stick_polar_deadzone_core #(
   parameter int CORDIC_STAGES = spdz_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_left_x,
   input  logic [15:0] req_left_y,
   input  logic [15:0] req_right_x,
   input  logic [15:0] req_right_y,
   input  logic        req_stick_sel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_magnitude_norm,
   output logic [15:0] rsp_angle_rad,
   output logic        rsp_in_deadzone,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int CHAIN = spdz_pkg::SQRT_STEPS + spdz_pkg::DIV_STEPS;

   logic [14:0] dz_ff;
   logic        advance;
   spdz_pkg::spdz_beat_type front_ff, front_in;
   spdz_pkg::spdz_beat_type links [CHAIN+1];

   // Output stage registers.
   logic        scale_valid_ff;
   logic [57:0] scale_prod_ff;
   logic [15:0] scale_mag_ff;
   logic        scale_inside_ff;
   logic        out_valid_ff;
   logic [15:0] out_mag_ff, out_ang_ff;
   logic        out_inside_ff;

   logic signed [15:0] sx, sy;
   logic [31:0] r2;
   logic [29:0] dz2;
   logic signed [16:0] ax, ay;
   logic [33:0] t_clamp;
   logic signed [36:0] t_sum;
   spdz_pkg::spdz_beat_type tail;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= 15'(spdz_pkg::DEADZONE_RESET);
      end else if (csr_wr_en) begin
         dz_ff <= csr_wr_data;
      end
   end

   // Front cell: select stick, square, fold into the first quadrant.
   always_comb begin
      front_in        = '0;
      sx              = req_stick_sel ? req_right_x : req_left_x;
      sy              = req_stick_sel ? req_right_y : req_left_y;
      r2              = 32'(sx * sx) + 32'(sy * sy);
      dz2             = dz_ff * dz_ff;
      front_in.valid  = req_valid;
      front_in.dz     = dz_ff;
      front_in.dz_hit = r2 < 32'(dz2);
      front_in.mag_on = (r2 > 32'(dz2)) && (dz_ff != 15'h7FFF);
      front_in.sq_rem = {r2, 16'd0};
      front_in.sq_bit = 48'h1 << 46;
      front_in.sq_res = '0;
      front_in.dv_den = {1'b0, (15'(spdz_pkg::AXIS_MAX) - dz_ff), 8'd0};
      front_in.z      = '0;
      front_in.axis   = (sx == 16'sd0) || (sy == 16'sd0);
      ax = '0;
      ay = '0;
      if (sx == 16'sd0 && sy == 16'sd0) begin
         front_in.base = '0;
      end else if (sx == 16'sd0) begin
         front_in.base = sy > 0 ? spdz_pkg::QUARTER_TURN : 34'(3 * spdz_pkg::QUARTER_TURN);
      end else if (sy == 16'sd0) begin
         front_in.base = sx > 0 ? '0 : 34'(2 * spdz_pkg::QUARTER_TURN);
      end else if (sx > 0 && sy > 0) begin
         front_in.base = '0;
         ax = 17'(sx);  ay = 17'(sy);
      end else if (sx < 0 && sy > 0) begin
         front_in.base = spdz_pkg::QUARTER_TURN;
         ax = 17'(sy);  ay = -17'(sx);
      end else if (sx < 0) begin
         front_in.base = 34'(2 * spdz_pkg::QUARTER_TURN);
         ax = -17'(sx); ay = -17'(sy);
      end else begin
         front_in.base = 34'(3 * spdz_pkg::QUARTER_TURN);
         ax = -17'(sy); ay = 17'(sx);
      end
      front_in.cx = {1'b0, ax[16:0], 16'd0};
      front_in.cy = 35'(ay) <<< 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   assign links[0] = front_ff;

   for (genvar g = 0; g < CHAIN; g++) begin : g_cell
      spdz_cell #(.IDX(g), .CORDIC_STAGES(CORDIC_STAGES)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (links[g]),
         .beat_out (links[g+1])
      );
   end

   assign tail = links[CHAIN];

   // Angle: base (plus CORDIC sum off axis), clamped, quarter turn added, scaled.
   always_comb begin
      t_sum = tail.axis ? 37'(tail.base) : 37'(tail.base) + 37'(tail.z);
      if (t_sum < 0) t_clamp = '0;
      else if (t_sum > 37'sh0FFFFFFFF) t_clamp = 34'h0FFFFFFFF;
      else t_clamp = 34'(t_sum);
      t_clamp = t_clamp + spdz_pkg::QUARTER_TURN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         scale_valid_ff <= tail.valid;
         out_valid_ff   <= scale_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         scale_prod_ff   <= 58'(t_clamp) * 58'(spdz_pkg::TWO_PI_Q21);
         scale_mag_ff    <= tail.mag_on ? tail.dv_quo : 16'd0;
         scale_inside_ff <= tail.dz_hit;
         out_mag_ff      <= scale_mag_ff;
         out_inside_ff   <= scale_inside_ff;
         out_ang_ff      <= scale_inside_ff ? 16'd0
                            : 16'((scale_prod_ff + (58'd1 << 39)) >> 40);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_magnitude_norm = out_mag_ff;
   assign rsp_angle_rad      = out_ang_ff;
   assign rsp_in_deadzone    = out_inside_ff;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for stick_polar_deadzone_core
// Drives stick samples through the valid/ready request channel with random
// gaps and back-pressure. Each accepted beat is scored against a fixed-point
// model of radius, dead-zone magnitude and CORDIC direction, or a typed row.
// The dead zone is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] mag;
      logic [15:0] ang;
      logic        dz_flag;
   } polar_type;

   typedef struct {
      int          dz;
      logic [15:0] lx, ly, rx, ry;
      logic        sel;
      bit          typed;    // expected values written in the row itself
      logic [15:0] mag, ang;
      logic        dz_flag;
   } dir_row_type;

   localparam longint QTURN = 64'd1073741824;
   localparam longint ATAN_T [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
   localparam int ITEMS_PER_PHASE = 280;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int LONG_STALL      = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_left_x = '0, req_left_y = '0, req_right_x = '0, req_right_y = '0;
   logic        req_stick_sel = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_magnitude_norm, rsp_angle_rad;
   logic        rsp_in_deadzone;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;

   // Dead zone as the core holds it, and the results still owed by the core.
   int        cur_deadzone = spdz_pkg::DEADZONE_RESET;
   polar_type pending_polar[$];
   int        fail_count = 0;
   int        rsp_count = 0;
   int        idle_cycles = 0;
   bit        rsp_busy_mode = 1'b0;
   int        rsp_hold = 0;

   stick_polar_deadzone_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_x(req_left_x), .req_left_y(req_left_y),
      .req_right_x(req_right_x), .req_right_y(req_right_y),
      .req_stick_sel(req_stick_sel),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_magnitude_norm(rsp_magnitude_norm), .rsp_angle_rad(rsp_angle_rad),
      .rsp_in_deadzone(rsp_in_deadzone),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bitwise integer square root, floor(sqrt(v)).
   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, bt;
      begin
         res = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt = bt >> 2;
         while (bt != 0) begin
            if (v >= res + bt) begin
               v = v - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
            bt = bt >> 2;
         end
         return res;
      end
   endfunction

   // Direction in units of 2^-32 turn. The axes are exact; everything else is
   // folded into the first quadrant and refined by CORDIC vectoring.
   function automatic longint heading_turns(longint x, longint y);
      longint base, ax, ay, z, cy, t, xs;
      bit [63:0] cx, ycomp;
      begin
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x == 0) return (y > 0) ? QTURN : 3 * QTURN;
         if (y == 0) return (x > 0) ? 0 : 2 * QTURN;
         if (x > 0 && y > 0) begin
            base = 0; ax = x; ay = y;
         end else if (x < 0 && y > 0) begin
            base = QTURN; ax = y; ay = -x;
         end else if (x < 0) begin
            base = 2 * QTURN; ax = -x; ay = -y;
         end else begin
            base = 3 * QTURN; ax = -y; ay = x;
         end
         cx = ax << 16;
         cy = ay * 65536;
         for (int i = 0; i < spdz_pkg::CORDIC_STAGES_DEF && i < 24; i++) begin
            ycomp = (cy >= 0) ? cy : -cy;
            xs = cx >> i;
            cx = cx + (ycomp >> i);
            if (cy >= 0) begin
               cy = cy - xs;
               z = z + ATAN_T[i];
            end else begin
               cy = cy + xs;
               z = z - ATAN_T[i];
            end
         end
         t = base + z;
         if (t < 0) t = 0;
         if (t > 4 * QTURN - 1) t = 4 * QTURN - 1;
         return t;
      end
   endfunction

   // Polar reading of the selected stick under dead zone dz.
   function automatic polar_type predict_polar(logic [15:0] lx, ly, rx, ry, logic sel, int dz);
      polar_type p;
      longint    x, y;
      bit [63:0] r2, dz2, rq, den, num, t;
      begin
         x = sel ? longint'($signed(rx)) : longint'($signed(lx));
         y = sel ? longint'($signed(ry)) : longint'($signed(ly));
         r2 = x * x + y * y;
         dz2 = dz * dz;
         p.dz_flag = (r2 < dz2);
         p.mag = 0;
         p.ang = 0;
         if (r2 > dz2 && dz < 32767) begin
            rq = int_sqrt(r2 << 16);
            if (rq > (64'd32767 << 8)) rq = 64'd32767 << 8;
            den = (32767 - dz) << 8;
            num = (rq - (dz << 8)) * 32768;
            p.mag = 16'((num + den / 2) / den);
         end
         if (!p.dz_flag) begin
            t = heading_turns(x, y) + QTURN;
            p.ang = 16'((t * 64'd13176795 + (64'd1 << 39)) >> 40);
         end
         return p;
      end
   endfunction

   // Offer one beat after a gap; valid stays up when the gap is zero.
   task automatic send_sample(logic [15:0] lx, ly, rx, ry, logic sel, int gap);
      begin
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_left_x <= lx;
         req_left_y <= ly;
         req_right_x <= rx;
         req_right_y <= ry;
         req_stick_sel <= sel;
         do @(posedge clock); while (!req_ready);
         pending_polar.push_back(predict_polar(lx, ly, rx, ry, sel, cur_deadzone));
      end
   endtask

   // Let the pipeline empty, then write the dead zone register.
   task automatic load_deadzone(int dz);
      begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending_polar.size() != 0) @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= dz[14:0];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         cur_deadzone = dz;
      end
   endtask

   // One axis value: full range, extremes, zero, or close to the dead zone.
   function automatic logic [15:0] pick_axis(int dz);
      int kind, lim;
      logic [15:0] v;
      begin
         kind = $urandom_range(0, 9);
         lim = (dz + 3 > 32767) ? 32767 : dz + 3;
         case (kind)
            0, 1, 2, 3: v = 16'($urandom());
            4:       v = 16'h0000;
            5:       begin
               case ($urandom_range(0, 5))
                  0: v = 16'h8000;
                  1: v = 16'h8001;
                  2: v = 16'hFFFF;
                  3: v = 16'h0001;
                  4: v = 16'h7FFF;
                  default: v = 16'h0000;
               endcase
            end
            6, 7, 8: v = 16'($urandom_range(0, lim));
            default: v = 16'($urandom_range(0, 2 * lim > 32767 ? 32767 : 2 * lim));
         endcase
         if (kind >= 6 && $urandom_range(0, 1)) v = -v;
         return v;
      end
   endfunction

   // Response side: random stalls per beat, stretches of none, and one long
   // hold-off so the chain backs up and the request side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_count % 150 == 0) rsp_busy_mode = $urandom_range(0, 1);
         if (rsp_count == 400) rsp_hold = LONG_STALL;
         else if (rsp_busy_mode) rsp_hold = $urandom_range(0, 15);
         else rsp_hold = 0;
         rsp_ready <= (rsp_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Scoreboard: every response beat must match the oldest prediction.
   always @(posedge clock) begin
      polar_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count = rsp_count + 1;
         if (pending_polar.size() == 0) begin
            $error("response beat with no prediction waiting");
            fail_count++;
         end else begin
            want = pending_polar.pop_front();
            if (rsp_magnitude_norm !== want.mag) begin
               $error("magnitude_norm expected %0d got %0d", want.mag, rsp_magnitude_norm);
               fail_count++;
            end
            if (rsp_angle_rad !== want.ang) begin
               $error("angle_rad expected %0d got %0d", want.ang, rsp_angle_rad);
               fail_count++;
            end
            if (rsp_in_deadzone !== want.dz_flag) begin
               $error("in_deadzone expected %0d got %0d", want.dz_flag, rsp_in_deadzone);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles where neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   dir_row_type dir_rows [] = '{
      // Reset dead zone: centered, the four axis extremes, on and just inside the edge.
      '{7849, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7849, 16'd32767, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 16'd12868, 1'b0},
      '{7849, 16'h8000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 16'd38604, 1'b0},
      '{7849, 16'd0, 16'd32767, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 16'd25736, 1'b0},
      '{7849, 16'd0, 16'h8000, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 16'd51472, 1'b0},
      '{7849, 16'd7849, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd12868, 1'b0},
      '{7849, 16'd7848, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7849, 16'hFFFF, 16'd1, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1},
      // Stick select: rows pick either side; the first has the unselected left far out.
      '{7849, 16'd32767, 16'd32767, 16'd0, 16'd0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7849, 16'd0, 16'd0, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7849, 16'd12345, 16'hA460, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7849, 16'h8000, 16'd32767, 16'd9000, 16'd9000, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7849, 16'd0, 16'd0, 16'hD000, 16'd20000, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
      // Zero dead zone: a centered stick points along +x.
      '{0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd12868, 1'b0},
      '{0, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
      // Largest dead zone: only the rim gives a magnitude.
      '{32766, 16'd32767, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32768, 16'd12868, 1'b0},
      '{32766, 16'd32766, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd12868, 1'b0},
      '{32766, 16'd0, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1},
      '{32766, 16'h8000, 16'h8000, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0}
   };

   initial begin
      int dz_plan [6];
      int gap;
      bit quiet;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; typed rows replace the model's prediction with their own.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].dz != cur_deadzone) load_deadzone(dir_rows[i].dz);
         send_sample(dir_rows[i].lx, dir_rows[i].ly, dir_rows[i].rx, dir_rows[i].ry,
                     dir_rows[i].sel, $urandom_range(0, 3));
         if (dir_rows[i].typed) begin
            pending_polar[pending_polar.size() - 1] =
               '{dir_rows[i].mag, dir_rows[i].ang, dir_rows[i].dz_flag};
         end
      end

      // Random phases, each under its own dead zone; every write waits for the
      // chain to drain, which also gives the full-drain pause on the sender.
      dz_plan = '{32766, 0, 1, $urandom_range(0, 32766), 7849, $urandom_range(0, 32766)};
      foreach (dz_plan[p]) begin
         load_deadzone(dz_plan[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 70 == 0) quiet = $urandom_range(0, 1);
            gap = quiet ? 0 : $urandom_range(0, 15);
            send_sample(pick_axis(cur_deadzone), pick_axis(cur_deadzone),
                        pick_axis(cur_deadzone), pick_axis(cur_deadzone),
                        $urandom_range(0, 1), gap);
         end
      end

      req_valid <= 1'b0;
      while (pending_polar.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
